### design/oba_pkg.sv
package oba_pkg;

	localparam logic [31:0] LOG2_10_DIV10_Q32 = 32'd1426757253;
	localparam logic [31:0] LN2_Q32           = 32'd2977044472;
	localparam int          TAYLOR_TERMS      = 12;
	localparam int          MAX_HALF_WINDOW   = 1024;
	localparam int          MAX_FRAME         = 65536;

	localparam logic [0:0]  REG_HALF_WINDOW   = 1'b0;
	localparam logic [0:0]  REG_FRAME_LENGTH  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOG,
		ST_FRAC,
		ST_TERM_MUL,
		ST_TERM_DIV,
		ST_SCALE,
		ST_ACCUM,
		ST_DIV,
		ST_OUT
	} oba_state_t;

	typedef struct packed {
		logic load;
		logic do_log;
		logic do_frac;
		logic term_mul;
		logic term_div_start;
		logic do_scale;
		logic do_accum;
		logic div_start;
		logic out_load;
	} oba_cmd_t;

	typedef struct packed {
		logic ignore;
		logic term_last;
		logic div_done;
		logic emit;
	} oba_sts_t;

endpackage

### design/oba_divider.sv
module oba_divider import oba_pkg::*; #(
	parameter int WW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   dividend,
	input  logic [WW-1:0] divisor,
	output logic          done,
	output logic [63:0]   quotient
);

	logic [63:0]  quo_q;
	logic [WW:0]  rem_q;
	logic [6:0]   cnt_q;
	logic         busy_q;
	logic [WW+1:0] trial;
	logic [WW+1:0] shifted;

	// restoring divide, one quotient bit per cycle; done holds until the next start
	assign shifted = {rem_q, quo_q[63]};
	assign trial   = shifted - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
				done   <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!trial[WW+1]) begin
				rem_q <= trial[WW:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[WW:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;

endmodule

### design/oba_datapath.sv
module oba_datapath import oba_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  oba_cmd_t           cmd,
	output oba_sts_t           sts,
	input  logic signed [15:0] db_sample,
	input  logic               frame_start,
	input  logic [10:0]        half_window,
	input  logic [16:0]        frame_length,
	output logic [63:0]        bin_power,
	output logic [15:0]        bin_index
);

	localparam int WW = $clog2(MAX_HALF_WINDOW + 1);

	logic [15:0]  mag_q;
	logic         neg_q;
	logic [47:0]  p_q;
	logic signed [10:0] e_q;
	logic [31:0]  t_q;
	logic [63:0]  prod_q;
	logic [31:0]  term_q;
	logic [35:0]  m_q;
	logic [3:0]   k_q;
	logic [63:0]  lin_q;
	logic [63:0]  cur_q, prev_q;
	logic [9:0]   wpos_q;
	logic [16:0]  cnt_q;
	logic [15:0]  bins_q;
	logic [15:0]  idx_q;
	logic         first_q;
	logic         emit_q;
	logic [63:0]  half_q;

	logic [WW-1:0] w_eff;
	logic [16:0]   len_eff;
	logic [39:0]   flo;
	logic [39:0]   f;
	logic signed [10:0] e_n;
	logic signed [11:0] s;
	logic [64:0]   sum65;
	logic [63:0]   lin_n;
	logic [127:0]  wide;
	logic [64:0]   add_n;
	logic [63:0]   quo;
	logic          div_done;
	logic [32:0]   recip;
	logic [2:0]    rsh;
	logic [64:0]   rprod;
	logic [32:0]   term_sh;
	logic [31:0]   term_n;

	// clamp config to its working range
	always_comb begin
		if (half_window == 11'd0)
			w_eff = WW'(1);
		else if (32'(half_window) > MAX_HALF_WINDOW)
			w_eff = WW'(MAX_HALF_WINDOW);
		else
			w_eff = WW'(half_window);
		if (32'(frame_length) > MAX_FRAME)
			len_eff = 17'(MAX_FRAME);
		else
			len_eff = frame_length;
	end

	assign flo = p_q[39:0];
	always_comb begin
		if (!neg_q) begin
			e_n = 11'(p_q[47:40]);
			f   = flo;
		end else if (flo == '0) begin
			e_n = -11'(p_q[47:40]);
			f   = '0;
		end else begin
			e_n = -11'(p_q[47:40]) - 11'sd1;
			f   = 40'd0 - flo;
		end
	end

	// floor(x / k) as (x * ceil(2^(32+l) / k)) >> (32 + l), l = ceil(log2 k)
	always_comb begin
		case (k_q)
			4'd2:    begin recip = 33'h1_0000_0000; rsh = 3'd1; end
			4'd3:    begin recip = 33'h1_5555_5556; rsh = 3'd2; end
			4'd4:    begin recip = 33'h1_0000_0000; rsh = 3'd2; end
			4'd5:    begin recip = 33'h1_9999_999A; rsh = 3'd3; end
			4'd6:    begin recip = 33'h1_5555_5556; rsh = 3'd3; end
			4'd7:    begin recip = 33'h1_2492_4925; rsh = 3'd3; end
			4'd8:    begin recip = 33'h1_0000_0000; rsh = 3'd3; end
			4'd9:    begin recip = 33'h1_C71C_71C8; rsh = 3'd4; end
			4'd10:   begin recip = 33'h1_9999_999A; rsh = 3'd4; end
			4'd11:   begin recip = 33'h1_745D_1746; rsh = 3'd4; end
			4'd12:   begin recip = 33'h1_5555_5556; rsh = 3'd4; end
			default: begin recip = 33'h1_0000_0000; rsh = 3'd0; end
		endcase
	end

	assign rprod   = 65'(prod_q[63:32]) * 65'(recip);
	assign term_sh = rprod[64:32] >> rsh;
	assign term_n  = term_sh[31:0];

	assign s    = 12'(e_q) + 12'sd8;
	assign wide = {92'd0, m_q} << s[6:0];
	always_comb begin
		if (s >= 0) begin
			if (s >= 12'sd64 || wide[127:64] != '0)
				lin_n = '1;
			else
				lin_n = wide[63:0];
		end else if (-s >= 12'sd64) begin
			lin_n = '0;
		end else begin
			lin_n = 64'(m_q) >> 7'(-s);
		end
	end

	assign add_n = {1'b0, cur_q} + {1'b0, lin_q};
	assign sum65 = {1'b0, add_n[64] ? 64'hFFFF_FFFF_FFFF_FFFF : add_n[63:0]} + {1'b0, prev_q};

	assign sts.ignore = frame_start ? (len_eff == 17'd0) : (cnt_q >= len_eff);
	assign sts.term_last = (k_q == 4'(TAYLOR_TERMS));
	assign sts.div_done = div_done;
	assign sts.emit = emit_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= db_sample[15];
			mag_q <= db_sample[15] ? 16'd0 - db_sample : db_sample;
		end
		if (cmd.do_log)
			p_q <= 48'({16'd0, mag_q} * {16'd0, LOG2_10_DIV10_Q32});
		if (cmd.do_frac) begin
			e_q    <= e_n;
			prod_q <= 64'(f[39:8]) * 64'(LN2_Q32);
			term_q <= 32'hFFFF_FFFF;
			m_q    <= 36'h1_0000_0000;
			k_q    <= 4'd1;
		end
		if (cmd.term_mul) begin
			if (k_q == 4'd1) begin
				t_q    <= prod_q[63:32];
				prod_q <= 64'(prod_q[63:32]) << 32;
			end else begin
				prod_q <= 64'(term_q) * 64'(t_q);
			end
		end
		if (cmd.term_div_start) begin
			term_q <= term_n;
			m_q    <= m_q + 36'(term_n);
			k_q    <= k_q + 4'd1;
		end
		if (cmd.do_scale)
			lin_q <= lin_n;
		if (cmd.out_load) begin
			bin_power <= quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q   <= '0;
			prev_q  <= '0;
			wpos_q  <= '0;
			cnt_q   <= '0;
			bins_q  <= '0;
			idx_q   <= '0;
			first_q <= 1'b0;
			emit_q  <= 1'b0;
			half_q  <= '0;
			bin_index <= '0;
		end else begin
			if (cmd.load && frame_start) begin
				cur_q   <= '0;
				prev_q  <= '0;
				wpos_q  <= '0;
				cnt_q   <= '0;
				bins_q  <= '0;
				first_q <= 1'b0;
			end
			if (cmd.do_accum) begin
				cnt_q  <= cnt_q + 17'd1;
				emit_q <= 1'b0;
				if (32'(wpos_q) + 1 >= 32'(w_eff)) begin
					if (first_q) begin
						emit_q <= 1'b1;
						half_q <= sum65[64:1];
						idx_q  <= bins_q;
						bins_q <= bins_q + 16'd1;
					end
					prev_q  <= add_n[64] ? '1 : add_n[63:0];
					cur_q   <= '0;
					wpos_q  <= '0;
					first_q <= 1'b1;
				end else begin
					cur_q  <= add_n[64] ? '1 : add_n[63:0];
					wpos_q <= wpos_q + 10'd1;
				end
			end
			if (cmd.out_load)
				bin_index <= idx_q;
		end
	end

	oba_divider #(.WW(WW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (half_q),
		.divisor  (w_eff),
		.done     (div_done),
		.quotient (quo)
	);

endmodule

### design/oba_ctrl.sv
module oba_ctrl import oba_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  oba_sts_t sts,
	output oba_cmd_t cmd
);

	oba_state_t state_q, state_n;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = sts.ignore ? ST_IDLE : ST_LOG;
				end
			end
			ST_LOG: begin
				cmd.do_log = 1'b1;
				state_n    = ST_FRAC;
			end
			ST_FRAC: begin
				cmd.do_frac = 1'b1;
				state_n     = ST_TERM_MUL;
			end
			ST_TERM_MUL: begin
				cmd.term_mul = 1'b1;
				state_n      = ST_TERM_DIV;
			end
			ST_TERM_DIV: begin
				cmd.term_div_start = 1'b1;
				state_n = sts.term_last ? ST_SCALE : ST_TERM_MUL;
			end
			ST_SCALE: begin
				cmd.do_scale = 1'b1;
				state_n      = ST_ACCUM;
			end
			ST_ACCUM: begin
				cmd.do_accum = 1'b1;
				state_n      = ST_DIV;
			end
			ST_DIV: begin
				if (sts.emit) begin
					cmd.div_start = 1'b1;
					state_n       = ST_OUT;
				end else begin
					state_n = ST_IDLE;
				end
			end
			ST_OUT: begin
				// hold the quotient until the output register is free
				if (sts.div_done) begin
					if (!out_valid_q || !out_stall) begin
						cmd.out_load = 1'b1;
						state_n      = ST_IDLE;
					end
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	a_no_load_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output beat overwritten");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE)
		else $error("load outside idle");
	a_out_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> state_q == ST_IDLE)
		else $error("bad state after output");

endmodule

### design/overlapping_bin_averager_unit.sv
// Overlapping half-window bin averager.
// Input channel: db_sample (dB x256, signed) and frame_start, with in_valid /
// in_stall; a beat is taken when in_valid is high and in_stall low.
// Output channel: bin_power (Q24.40) and bin_index, out_valid / out_stall.
// Config channel: cfg_valid / cfg_ready, cfg_index 0 = half_window,
// 1 = frame_length; write only while idle.
// Each beat is converted to linear power by a 12-term series, one term
// at a time (a 32x32 product, then a reciprocal multiply for the divide
// by the term number); no new beat is taken until a beat is finished. A
// beat that closes a half-window (other than the first) also runs the
// 64-step restoring divider, and the next beat is taken only after its
// result has been loaded into the output register.
// Samples beyond the frame length are accepted and dropped.
// Reset clears all sums and counters and restores half_window = 16 and
// frame_length = 4096. A stalled result holds in the output register; the
// block keeps taking beats and only waits if a second result is ready.
module overlapping_bin_averager_unit import oba_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] db_sample,
	input  logic               frame_start,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [63:0]        bin_power,
	output logic [15:0]        bin_index,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [16:0]        cfg_data
);

	logic [10:0] half_window_q;
	logic [16:0] frame_length_q;
	oba_cmd_t    cmd;
	oba_sts_t    sts;

	assign cfg_ready = 1'b1;

	// register writes take effect at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_window_q  <= 11'd16;
			frame_length_q <= 17'd4096;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HALF_WINDOW:  half_window_q  <= cfg_data[10:0];
				REG_FRAME_LENGTH: frame_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	oba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	oba_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.db_sample    (db_sample),
		.frame_start  (frame_start),
		.half_window  (half_window_q),
		.frame_length (frame_length_q),
		.bin_power    (bin_power),
		.bin_index    (bin_index)
	);

endmodule
